// File: hw/rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types, codes and constants of the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 10;   // stuffed byte count, holds the limit itself
  localparam int unsigned LenW   = 9;    // destuffed payload length
  localparam int unsigned KindW  = 2;
  localparam int unsigned CauseW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxStuffedBytesDefault = 512;
  localparam int unsigned LenLimit               = 512;

  localparam logic [ByteW-1:0] FlagByte = 8'h7E;
  localparam logic [ByteW-1:0] EscByte  = 8'h7D;
  localparam logic [ByteW-1:0] EscFlag  = 8'h5E;
  localparam logic [ByteW-1:0] EscEsc   = 8'h5D;

  localparam logic [ByteW-1:0] AddressReset     = 8'h03;
  localparam logic [ByteW-1:0] ControlReset     = 8'h00;
  localparam logic [ByteW-1:0] HeaderCheckReset = 8'h03;
  localparam logic             ModeReset        = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_BCC2     = 3'd1,
    CAUSE_EMPTY    = 3'd2,
    CAUSE_ESCAPE   = 3'd3,
    CAUSE_OVERFLOW = 3'd4
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADDRESS      = 2'd0,
    CFG_CONTROL      = 2'd1,
    CFG_HEADER_CHECK = 2'd2,
    CFG_MODE         = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    HS_HUNT = 5'b00001,
    HS_FLAG = 5'b00010,
    HS_ADDR = 5'b00100,
    HS_CTRL = 5'b01000,
    HS_DATA = 5'b10000
  } hdr_state_e;

  typedef struct packed {
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] control;
    logic [ByteW-1:0] header_check;
    logic             mode;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  out_kind;
    logic [ByteW-1:0]  out_byte;
    logic [LenW-1:0]   payload_length;
    logic [CauseW-1:0] reject_cause;
  } res_t;

  // Handshake between the input stage and the frame logic.
  typedef struct packed {
    logic             step;
    logic [ByteW-1:0] rx_byte;
  } beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsfr_rx_if.sv
// ----------------------------------------------------------------------------
// bsfr_rx_if
// Channel carrying raw received bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfr_rx_if;
  logic                       valid;
  logic                       ready;
  logic [bsfr_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bsfr_res_if.sv
// ----------------------------------------------------------------------------
// bsfr_res_if
// Channel carrying payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [bsfr_pkg::KindW-1:0]  out_kind;
  logic [bsfr_pkg::ByteW-1:0]  out_byte;
  logic [bsfr_pkg::LenW-1:0]   payload_length;
  logic [bsfr_pkg::CauseW-1:0] reject_cause;

  modport source (output valid, output out_kind, output out_byte,
                  output payload_length, output reject_cause, input ready);
  modport sink (input valid, input out_kind, input out_byte,
                input payload_length, input reject_cause, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Flag hunt, header match and on-the-fly destuffing of byte-stuffed frames.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                          Beat
//  rx_i     in   rx_byte                                          valid & ready
//  res_o    out  out_kind, out_byte, payload_length, reject_cause valid & ready
//  cfg      in   cfg_index_i, cfg_data_i                          cfg_we_i
//
//  One byte per cycle while the result register is not stalled: a byte waits in
//  the input register, the frame logic settles it in a single pass and the
//  result register follows. Reset clears the header state, frame bookkeeping
//  and both valid flags; configuration registers go to their defaults.
//  A stalled result register holds the logic and the input register; both
//  keep taking beats whenever the register ahead frees up in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_receiver #(
  parameter int unsigned MAX_STUFFED_BYTES = bsfr_pkg::MaxStuffedBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bsfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bsfr_pkg::ByteW-1:0]   cfg_data_i,
  bsfr_rx_if.sink                           rx_i,
  bsfr_res_if.source                        res_o
);

  bsfr_pkg::cfg_t  cfg_q;
  bsfr_pkg::beat_t beat;
  bsfr_pkg::res_t  res;
  bsfr_pkg::res_t  out;
  logic            res_valid;
  logic            advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address      <= bsfr_pkg::AddressReset;
      cfg_q.control      <= bsfr_pkg::ControlReset;
      cfg_q.header_check <= bsfr_pkg::HeaderCheckReset;
      cfg_q.mode         <= bsfr_pkg::ModeReset;
    end else if (cfg_we_i) begin
      unique case (bsfr_pkg::cfg_idx_e'(cfg_index_i))
        bsfr_pkg::CFG_ADDRESS:      cfg_q.address      <= cfg_data_i;
        bsfr_pkg::CFG_CONTROL:      cfg_q.control      <= cfg_data_i;
        bsfr_pkg::CFG_HEADER_CHECK: cfg_q.header_check <= cfg_data_i;
        bsfr_pkg::CFG_MODE:         cfg_q.mode         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bsfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .in_byte_i  (rx_i.rx_byte),
    .advance_i  (advance),
    .beat_o     (beat)
  );

  bsfr_deframer #(
    .MAX_STUFFED_BYTES (MAX_STUFFED_BYTES)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .beat_i      (beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bsfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (out)
  );

  assign res_o.out_kind       = out.out_kind;
  assign res_o.out_byte       = out.out_byte;
  assign res_o.payload_length = out.payload_length;
  assign res_o.reject_cause   = out.reject_cause;

endmodule

`default_nettype wire

// File: hw/rtl/bsfr_in_reg.sv
// ----------------------------------------------------------------------------
// bsfr_in_reg
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_in_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bsfr_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       advance_i,
  output bsfr_pkg::beat_t                 beat_o
);

  logic                       valid_q, valid_d;
  logic [bsfr_pkg::ByteW-1:0] byte_q;
  logic                       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign beat_o.step    = valid_q && advance_i;
  assign beat_o.rx_byte = byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/bsfr_deframer.sv
// ----------------------------------------------------------------------------
// bsfr_deframer
// Header matching, destuffing, BCC2 tracking and frame verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_deframer #(
  parameter int unsigned MAX_STUFFED_BYTES = bsfr_pkg::MaxStuffedBytesDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bsfr_pkg::cfg_t   cfg_i,
  input  wire bsfr_pkg::beat_t  beat_i,
  output logic                  res_valid_o,
  output bsfr_pkg::res_t        res_o
);

  localparam int unsigned Limit = (MAX_STUFFED_BYTES > bsfr_pkg::LenLimit) ?
                                  bsfr_pkg::LenLimit : MAX_STUFFED_BYTES;

  bsfr_pkg::hdr_state_e        state_q, state_d;
  logic                        esc_q, esc_d;
  logic [bsfr_pkg::ByteW-1:0]  held_q, held_d;
  logic                        held_valid_q, held_valid_d;
  logic [bsfr_pkg::ByteW-1:0]  xor_q, xor_d;
  logic [bsfr_pkg::CntW-1:0]   stuffed_q, stuffed_d;
  logic [bsfr_pkg::LenW-1:0]   destuffed_q, destuffed_d;
  logic                        ovf_q, ovf_d;

  logic [bsfr_pkg::ByteW-1:0]  b;
  logic [bsfr_pkg::ByteW-1:0]  dbyte;
  logic                        is_flag;
  logic                        push;
  logic                        clear;

  assign b       = beat_i.rx_byte;
  assign is_flag = (b == bsfr_pkg::FlagByte);

  always_comb begin
    state_d      = state_q;
    esc_d        = esc_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    xor_d        = xor_q;
    stuffed_d    = stuffed_q;
    destuffed_d  = destuffed_q;
    ovf_d        = ovf_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    dbyte        = '0;
    push         = 1'b0;
    clear        = 1'b0;

    unique case (state_q)
      bsfr_pkg::HS_FLAG: begin
        if (is_flag) begin
          state_d = bsfr_pkg::HS_FLAG;
        end else if (b == cfg_i.address) begin
          state_d = bsfr_pkg::HS_ADDR;
        end else begin
          state_d = bsfr_pkg::HS_HUNT;
        end
      end
      bsfr_pkg::HS_ADDR: begin
        if (is_flag) begin
          state_d = bsfr_pkg::HS_FLAG;
        end else if (b == cfg_i.control) begin
          state_d = bsfr_pkg::HS_CTRL;
        end else begin
          state_d = bsfr_pkg::HS_HUNT;
        end
      end
      bsfr_pkg::HS_CTRL: begin
        if (is_flag) begin
          state_d = bsfr_pkg::HS_FLAG;
        end else if (b == cfg_i.header_check) begin
          state_d = bsfr_pkg::HS_DATA;
          clear   = 1'b1;
        end else begin
          state_d = bsfr_pkg::HS_HUNT;
        end
      end
      bsfr_pkg::HS_DATA: begin
        if (is_flag) begin
          // Closing flag: give the verdict and reopen on this same flag.
          res_valid_o = 1'b1;
          priority if (!cfg_i.mode) begin
            res_o.out_kind = bsfr_pkg::KIND_ACCEPT;
          end else if (ovf_q) begin
            res_o.out_kind     = bsfr_pkg::KIND_REJECT;
            res_o.reject_cause = bsfr_pkg::CAUSE_OVERFLOW;
          end else if (esc_q) begin
            res_o.out_kind     = bsfr_pkg::KIND_REJECT;
            res_o.reject_cause = bsfr_pkg::CAUSE_ESCAPE;
          end else if (!held_valid_q || destuffed_q == '0) begin
            res_o.out_kind     = bsfr_pkg::KIND_REJECT;
            res_o.reject_cause = bsfr_pkg::CAUSE_EMPTY;
          end else if (held_q != xor_q) begin
            res_o.out_kind     = bsfr_pkg::KIND_REJECT;
            res_o.reject_cause = bsfr_pkg::CAUSE_BCC2;
          end else begin
            res_o.out_kind       = bsfr_pkg::KIND_ACCEPT;
            res_o.payload_length = destuffed_q;
          end
          clear   = 1'b1;
          state_d = bsfr_pkg::HS_FLAG;
        end else if (!cfg_i.mode) begin
          clear   = 1'b1;
          state_d = bsfr_pkg::HS_HUNT;
        end else if (ovf_q || stuffed_q >= bsfr_pkg::CntW'(Limit)) begin
          ovf_d = 1'b1;
        end else begin
          stuffed_d = stuffed_q + 1'b1;
          if (esc_q) begin
            esc_d = 1'b0;
            push  = 1'b1;
            if (b == bsfr_pkg::EscFlag) begin
              dbyte = bsfr_pkg::FlagByte;
            end else if (b == bsfr_pkg::EscEsc) begin
              dbyte = bsfr_pkg::EscByte;
            end else begin
              dbyte = '0;
            end
          end else if (b == bsfr_pkg::EscByte) begin
            esc_d = 1'b1;
          end else begin
            dbyte = b;
            push  = 1'b1;
          end
          // The newest byte is held back as the BCC2 candidate; the one it
          // displaces goes out as payload.
          if (push) begin
            if (held_valid_q) begin
              res_valid_o    = 1'b1;
              res_o.out_kind = bsfr_pkg::KIND_DATA;
              res_o.out_byte = held_q;
              xor_d          = xor_q ^ held_q;
              destuffed_d    = destuffed_q + 1'b1;
            end
            held_d       = dbyte;
            held_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = is_flag ? bsfr_pkg::HS_FLAG : bsfr_pkg::HS_HUNT;
      end
    endcase

    if (clear) begin
      esc_d        = 1'b0;
      held_d       = '0;
      held_valid_d = 1'b0;
      xor_d        = '0;
      stuffed_d    = '0;
      destuffed_d  = '0;
      ovf_d        = 1'b0;
    end

    if (!beat_i.step) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bsfr_pkg::HS_HUNT;
      esc_q        <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      xor_q        <= '0;
      stuffed_q    <= '0;
      destuffed_q  <= '0;
      ovf_q        <= 1'b0;
    end else if (beat_i.step) begin
      state_q      <= state_d;
      esc_q        <= esc_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      xor_q        <= xor_d;
      stuffed_q    <= stuffed_d;
      destuffed_q  <= destuffed_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsfr_out_reg.sv
// ----------------------------------------------------------------------------
// bsfr_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  input  wire bsfr_pkg::res_t res_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bsfr_pkg::res_t      out_o
);

  logic           valid_q, valid_d;
  bsfr_pkg::res_t res_q;

  // The logic may move on whenever the register is free or being emptied.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// File: bench/frame_stream_check.sv
// ----------------------------------------------------------------------------
// frame_stream_check
// Watches the byte and result channels of the frame receiver, predicts every
// payload byte and frame verdict from the accepted input bytes and compares
// each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_stream_check
  import bsfr_pkg::*;
#(
  parameter int unsigned MAX_STUFFED_BYTES = MaxStuffedBytesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  bsfr_rx_if                      rx_mon,
  bsfr_res_if                     res_mon,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  localparam int unsigned StuffLimit =
      (MAX_STUFFED_BYTES > LenLimit) ? LenLimit : MAX_STUFFED_BYTES;

  cfg_t             cfg_q;
  hdr_state_e       hdr_q;
  logic             escaped_q;
  logic             held_valid_q;
  logic             overflow_q;
  logic [ByteW-1:0] held_q;
  logic [ByteW-1:0] xor_q;
  logic [CntW-1:0]  stuffed_q;
  logic [CntW-1:0]  length_q;

  res_t        expected_q[$];
  res_t        want;
  int unsigned mismatches = 0;

  function automatic res_t make_result(input kind_e kind, input logic [ByteW-1:0] data,
                                       input logic [LenW-1:0] len, input cause_e cause);
    res_t r;
    r.out_kind       = kind;
    r.out_byte       = data;
    r.payload_length = len;
    r.reject_cause   = cause;
    return r;
  endfunction

  function void clear_payload();
    escaped_q    = 1'b0;
    held_valid_q = 1'b0;
    overflow_q   = 1'b0;
    held_q       = '0;
    xor_q        = '0;
    stuffed_q    = '0;
    length_q     = '0;
  endfunction

  // Advances the frame state by one received byte and queues what it yields.
  function void predict_beat(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] d;
    d = b;
    case (hdr_q)
      HS_FLAG: begin
        if (b == FlagByte) hdr_q = HS_FLAG;
        else if (b == cfg_q.address) hdr_q = HS_ADDR;
        else hdr_q = HS_HUNT;
      end
      HS_ADDR: begin
        if (b == FlagByte) hdr_q = HS_FLAG;
        else if (b == cfg_q.control) hdr_q = HS_CTRL;
        else hdr_q = HS_HUNT;
      end
      HS_CTRL: begin
        if (b == FlagByte) begin
          hdr_q = HS_FLAG;
        end else if (b == cfg_q.header_check) begin
          hdr_q = HS_DATA;
          clear_payload();
        end else begin
          hdr_q = HS_HUNT;
        end
      end
      HS_DATA: begin
        if (b == FlagByte) begin
          if (!cfg_q.mode) begin
            expected_q.push_back(make_result(KIND_ACCEPT, '0, '0, CAUSE_NONE));
          end else if (overflow_q) begin
            expected_q.push_back(make_result(KIND_REJECT, '0, '0, CAUSE_OVERFLOW));
          end else if (escaped_q) begin
            expected_q.push_back(make_result(KIND_REJECT, '0, '0, CAUSE_ESCAPE));
          end else if (!held_valid_q || length_q == 0) begin
            expected_q.push_back(make_result(KIND_REJECT, '0, '0, CAUSE_EMPTY));
          end else if (held_q != xor_q) begin
            expected_q.push_back(make_result(KIND_REJECT, '0, '0, CAUSE_BCC2));
          end else begin
            expected_q.push_back(make_result(KIND_ACCEPT, '0, length_q[LenW-1:0],
                                             CAUSE_NONE));
          end
          clear_payload();
          hdr_q = HS_FLAG;
        end else if (!cfg_q.mode) begin
          clear_payload();
          hdr_q = HS_HUNT;
        end else if (overflow_q || stuffed_q >= StuffLimit) begin
          overflow_q = 1'b1;
        end else begin
          stuffed_q = stuffed_q + 1'b1;
          if (!escaped_q && b == EscByte) begin
            escaped_q = 1'b1;
          end else begin
            if (escaped_q) begin
              if (b == EscFlag) d = FlagByte;
              else if (b == EscEsc) d = EscByte;
              else d = '0;
            end
            escaped_q = 1'b0;
            // The newest byte is held back as the candidate BCC2.
            if (held_valid_q) begin
              expected_q.push_back(make_result(KIND_DATA, held_q, '0, CAUSE_NONE));
              xor_q    = xor_q ^ held_q;
              length_q = length_q + 1'b1;
            end
            held_q       = d;
            held_valid_q = 1'b1;
          end
        end
      end
      default: hdr_q = (b == FlagByte) ? HS_FLAG : HS_HUNT;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = '{AddressReset, ControlReset, HeaderCheckReset, ModeReset};
      hdr_q = HS_HUNT;
      clear_payload();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: out_kind %0d out_byte %0d", res_mon.out_kind,
                 res_mon.out_byte);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (res_mon.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, actual %0d", want.out_kind, res_mon.out_kind);
            mismatches++;
          end
          if (res_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, res_mon.out_byte);
            mismatches++;
          end
          if (res_mon.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, actual %0d", want.payload_length,
                   res_mon.payload_length);
            mismatches++;
          end
          if (res_mon.reject_cause !== want.reject_cause) begin
            $error("reject_cause: expected %0d, actual %0d", want.reject_cause,
                   res_mon.reject_cause);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ADDRESS:      cfg_q.address      = cfg_data_i;
          CFG_CONTROL:      cfg_q.control      = cfg_data_i;
          CFG_HEADER_CHECK: cfg_q.header_check = cfg_data_i;
          CFG_MODE:         cfg_q.mode         = cfg_data_i[0];
          default: ;
        endcase
      end
      if (rx_mon.valid && rx_mon.ready) predict_beat(rx_mon.rx_byte);
      pending_o <= expected_q.size();
    end
  end

  assign fail_count_o = mismatches;

endmodule

// File: bench/byte_stuffed_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_tb
// Feeds the frame receiver with directed frames, then random frames, broken
// headers and line noise under several register settings and handshake
// patterns, including long frames and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  localparam int unsigned MaxStuffed = MaxStuffedBytesDefault;
  localparam int unsigned PipeDelay  = 4;
  localparam int unsigned HoldCycles = 300;

  typedef logic [ByteW-1:0] byte_q_t[$];
  typedef enum int unsigned {FR_GOOD, FR_BAD_BCC, FR_ODD_ESC, FR_TRAIL_ESC} frame_flaw_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  bsfr_rx_if  rx_if();
  bsfr_res_if res_if();

  int unsigned      pending;
  int unsigned      failures;
  int unsigned      tx_idle_pct = 31;
  int unsigned      rx_idle_pct = 82;
  int unsigned      hold_requests = 0;
  int unsigned      bytes_sent = 0;
  logic [ByteW-1:0] last_sent = '0;
  cfg_t             cfg_now;

  byte_stuffed_frame_receiver #(
    .MAX_STUFFED_BYTES(MaxStuffed)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  frame_stream_check #(
    .MAX_STUFFED_BYTES(MaxStuffed)
  ) stream_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_mon      (rx_if),
    .res_mon     (res_if),
    .pending_o   (pending),
    .fail_count_o(failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Output side: random back-pressure, plus a long hold whenever one is requested.
  initial begin : ready_drive
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(15))
      0: return FlagByte;
      1: return EscByte;
      2: return EscFlag;
      3: return EscEsc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(255)); while (b == FlagByte || b == EscByte);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] header_byte();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(255)); while (b == FlagByte);
    return b;
  endfunction

  function automatic void stuff_byte(ref byte_q_t q, input logic [ByteW-1:0] b);
    if (b == FlagByte) begin
      q.push_back(EscByte);
      q.push_back(EscFlag);
    end else if (b == EscByte) begin
      q.push_back(EscByte);
      q.push_back(EscEsc);
    end else begin
      q.push_back(b);
    end
  endfunction

  function automatic byte_q_t frame_header(input cfg_t c);
    byte_q_t q;
    q.push_back(c.address);
    q.push_back(c.control);
    q.push_back(c.header_check);
    return q;
  endfunction

  // Header, stuffed payload with an optional odd escape and, in information mode, the BCC2 with an optional flaw.
  function automatic byte_q_t frame_body(input cfg_t c, input int unsigned len,
                                         input frame_flaw_e flaw, input bit plain);
    byte_q_t          q;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] nb;
    logic [ByteW-1:0] sum;
    q   = frame_header(c);
    sum = '0;
    if (flaw == FR_ODD_ESC) begin
      // An escape before an ordinary byte destuffs to zero, so the sum is unchanged.
      q.push_back(EscByte);
      do b = 8'($urandom_range(255)); while (b == EscFlag || b == EscEsc || b == FlagByte);
      q.push_back(b);
    end
    for (int i = 0; i < len; i++) begin
      b   = plain ? plain_byte() : pick_byte();
      sum = sum ^ b;
      stuff_byte(q, b);
    end
    // A plain frame must keep its exact stuffed length, so its BCC2 needs no escape.
    while (plain && len > 0 && (sum == FlagByte || sum == EscByte)) begin
      b   = q.pop_back();
      nb  = plain_byte();
      q.push_back(nb);
      sum = sum ^ b ^ nb;
    end
    if (c.mode) begin
      if (flaw == FR_BAD_BCC) sum = sum ^ 8'(1 << $urandom_range(7));
      stuff_byte(q, sum);
      if (flaw == FR_TRAIL_ESC) q.push_back(EscByte);
    end
    return q;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    last_sent = b;
    bytes_sent++;
  endtask

  // The closing flag of one frame may open the next one.
  task automatic send_frame(input byte_q_t body);
    if (last_sent != FlagByte || $urandom_range(1) == 1) send_byte(FlagByte);
    foreach (body[i]) send_byte(body[i]);
    send_byte(FlagByte);
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_t c);
    drain();
    repeat (PipeDelay) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      case (cfg_idx_e'(i))
        CFG_ADDRESS:      cfg_data_i <= c.address;
        CFG_CONTROL:      cfg_data_i <= c.control;
        CFG_HEADER_CHECK: cfg_data_i <= c.header_check;
        default:          cfg_data_i <= {7'($urandom_range(127)), c.mode};
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_now = c;
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    frame_flaw_e flaw;
    byte_q_t     q;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        flaw = FR_GOOD;
        if (!cfg_now.mode) begin
          len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
        end else begin
          len  = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
          pick = $urandom_range(99);
          if (pick >= 93) flaw = FR_TRAIL_ESC;
          else if (pick >= 85) flaw = FR_ODD_ESC;
          else if (pick >= 70) flaw = FR_BAD_BCC;
        end
        send_frame(frame_body(cfg_now, len, flaw, 1'b0));
      end else if (pick < 80) begin
        // A header that breaks off after zero to two matching bytes.
        q    = frame_header(cfg_now);
        keep = $urandom_range(2);
        send_byte(FlagByte);
        for (int i = 0; i < keep; i++) send_byte(q[i]);
        send_byte(pick_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte());
      end
    end
  endtask

  initial begin : stimulus
    cfg_t        setting;
    byte_q_t     q;
    int unsigned count;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_ADDRESS;
    cfg_data_i    <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_now = '{AddressReset, ControlReset, HeaderCheckReset, ModeReset};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings.
    send_byte(8'h00);
    send_byte(8'hFF);
    q = frame_header(cfg_now);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    stuff_byte(q, FlagByte);
    stuff_byte(q, EscByte);
    q.push_back(8'hFC);
    send_frame(q);
    send_frame(frame_header(cfg_now));
    send_frame(frame_body(cfg_now, 0, FR_GOOD, 1'b0));
    send_frame(frame_body(cfg_now, 2, FR_BAD_BCC, 1'b0));
    send_frame(frame_body(cfg_now, 0, FR_ODD_ESC, 1'b0));
    send_frame(frame_body(cfg_now, 1, FR_TRAIL_ESC, 1'b0));
    // A flag in any header state restarts the header.
    send_byte(cfg_now.address);
    send_byte(FlagByte);
    send_byte(cfg_now.address);
    send_byte(FlagByte);
    send_byte(cfg_now.address);
    send_byte(cfg_now.control);
    send_byte(FlagByte);
    send_frame(frame_body(cfg_now, 3, FR_GOOD, 1'b0));
    send_byte(cfg_now.address);
    send_byte(cfg_now.control ^ 8'h01);
    send_byte(FlagByte);
    send_byte(cfg_now.address);
    send_byte(cfg_now.control);
    send_byte(cfg_now.header_check ^ 8'h80);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: setting = '{8'h00, 8'hFF, 8'hFF, 1'b1};
        1: setting = '{8'hFF, 8'h00, 8'h00, 1'b0};
        3: setting = '{FlagByte, header_byte(), header_byte(), 1'b1};
        default: setting = '{header_byte(), header_byte(), header_byte(), p != 4};
      endcase
      case (p)
        0, 1: begin
          tx_idle_pct = 31;
          rx_idle_pct = 82;
        end
        2, 3: begin
          tx_idle_pct = 82;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      count = (p == 3) ? 20 : 45;
      write_cfg(setting);
      random_traffic(count);
    end

    // The output holds off while a long frame keeps arriving.
    hold_requests <= hold_requests + 1;
    send_frame(frame_body(cfg_now, 60, FR_GOOD, 1'b0));
    drain();
    send_frame(frame_body(cfg_now, 5, FR_GOOD, 1'b0));

    drain();
    repeat (PipeDelay * 4) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
